/* sv/qpmm_pkg.sv */
`default_nettype none
package qpmm_pkg;

  // Default coordinate width: unsigned fixed point with four fraction bits.
  localparam int COORD_BITS_DEF = 16;

  // Marker size register.
  localparam int          MARKER_W     = 10;
  localparam logic [9:0]  MARKER_RESET = 10'd70;

  // Configuration port.
  localparam int          CFG_ADDR_W = 3;
  localparam int          CFG_DATA_W = 32;
  localparam logic [0:0]  REG_MARKER = 1'b0;

  // Bit positions in the result sideband.
  localparam int TU_SAT = 0;
  localparam int TU_DEG = 1;
  localparam int TU_W   = 2;

  // Corner count and fraction bits.
  localparam int CORNERS   = 4;
  localparam int FRAC_BITS = 4;

endpackage
`default_nettype wire

/* sv/qpmm_sqrt.sv */
`default_nettype none
module qpmm_sqrt #(
  parameter int W = 17
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] op,
  output logic      [W-1:0]   root
);

  // One result bit per stage, restoring square root.
  logic [2*W-1:0] s_r    [W];
  logic [W+1:0]   rem_r  [W];
  logic [W-1:0]   root_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] s_p;
    logic [W+1:0]   rem_p;
    logic [W-1:0]   root_p;
    logic [W+3:0]   rem_sh;
    logic [W+3:0]   trial;
    logic [W+3:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign s_p    = op;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign s_p    = s_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // Bring down the next bit pair and try the odd trial value.
    always_comb begin
      rem_sh = {rem_p, s_p[2*W-1 -: 2]};
      trial  = {2'b00, root_p, 2'b01};
      ge     = (rem_sh >= trial);
      diff   = rem_sh - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]    <= s_p << 2;
        rem_r[k]  <= ge ? diff[W+1:0] : rem_sh[W+1:0];
        root_r[k] <= {root_p[W-2:0], ge};
      end
    end
  end

  assign root = root_r[W-1];

endmodule
`default_nettype wire

/* sv/qpmm_div.sv */
`default_nettype none
module qpmm_div #(
  parameter int C = 16
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [C+13:0] num,
  input  wire logic [C:0]   mean,
  output logic      [C-1:0] q,
  output logic              sat
);

  localparam int NW = C + 15;
  localparam int XW = 2 * C + 17;

  logic [NW-1:0] rem_r [C+1];
  logic [C+1:0]  d_r   [C+1];
  logic [C-1:0]  q_r   [C+1];
  logic          sat_r [C+1];

  // Rounded quotient: (2*num + mean) / (2*mean); overflow is found up front.
  logic [NW-1:0] n0;
  logic [C+1:0]  d0;
  always_comb begin
    n0 = {num, 1'b0} + NW'(mean);
    d0 = {mean, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n0;
      d_r[0]   <= d0;
      q_r[0]   <= '0;
      sat_r[0] <= (XW'(n0) >= (XW'(d0) << C));
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= C; k++) begin : g_stage
    localparam int SH = C - k;
    logic [XW-1:0] dsh;
    logic [XW-1:0] sub;
    logic          ge;

    always_comb begin
      dsh = XW'(d_r[k-1]) << SH;
      ge  = (XW'(rem_r[k-1]) >= dsh);
      sub = XW'(rem_r[k-1]) - dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? sub[NW-1:0] : rem_r[k-1];
        d_r[k]   <= d_r[k-1];
        q_r[k]   <= {q_r[k-1][C-2:0], ge};
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign q   = q_r[C];
  assign sat = sat_r[C];

endmodule
`default_nettype wire

/* sv/quad_pixel_to_mm_scaler_unit.sv */
// Marker quad scaler: takes four corners in pixels (unsigned, four fraction bits) and
// returns them in millimetres, scaled by the marker size register over the mean of the
// four closed-loop side lengths. One quad is taken every cycle unless the result side
// stalls. The pipeline holds 2*COORD_BITS+8 register stages (40 at the default width),
// from the input register to the output register. The latency is set by the side root
// and quotient pipelines, which resolve one bit per stage. A stall on the result side
// holds the whole pipeline, and no transfer is lost or repeated.
`default_nettype none
module quad_pixel_to_mm_scaler_unit #(
  parameter int COORD_BITS = qpmm_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // mm0_x, mm0_y, mm1_x, mm1_y, mm2_x, mm2_y, mm3_x, mm3_y, mean_side_px
  output logic [((9*COORD_BITS+8)/8)*8-1:0] out_tdata,
  // saturated, degenerate
  output logic [qpmm_pkg::TU_W-1:0] out_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [qpmm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [qpmm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qpmm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic      cfg_pready
);
  import qpmm_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int W     = C + 1;
  localparam int PW    = C + MARKER_W;
  localparam int L     = 2 * C + 8;
  localparam int OUT_W = ((9 * C + 8) / 8) * 8;
  localparam int NC    = 2 * CORNERS;

  // Marker size register.
  logic [MARKER_W-1:0] marker_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(marker_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[CFG_ADDR_W-1] == REG_MARKER) begin
      marker_r <= cfg_pwdata[MARKER_W-1:0];
    end
  end

  // Pipeline flow: everything moves unless a result waits untaken.
  logic         adv;
  logic [L-1:0] vld_r;
  assign adv        = !vld_r[L-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  // Input register.
  logic [C-1:0]        crd_a_r [NC];
  logic [MARKER_W-1:0] mk_a_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NC; j++) crd_a_r[j] <= in_tdata[j*C +: C];
      mk_a_r <= marker_r;
    end
  end

  // Absolute corner differences for each side.
  logic [C-1:0]        dx_b_r  [CORNERS];
  logic [C-1:0]        dy_b_r  [CORNERS];
  logic [C-1:0]        crd_b_r [NC];
  logic [MARKER_W-1:0] mk_b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CORNERS; k++) begin
        dx_b_r[k] <= (crd_a_r[2*k] >= crd_a_r[2*((k+1)%CORNERS)]) ?
                     crd_a_r[2*k] - crd_a_r[2*((k+1)%CORNERS)] :
                     crd_a_r[2*((k+1)%CORNERS)] - crd_a_r[2*k];
        dy_b_r[k] <= (crd_a_r[2*k+1] >= crd_a_r[2*((k+1)%CORNERS)+1]) ?
                     crd_a_r[2*k+1] - crd_a_r[2*((k+1)%CORNERS)+1] :
                     crd_a_r[2*((k+1)%CORNERS)+1] - crd_a_r[2*k+1];
      end
      crd_b_r <= crd_a_r;
      mk_b_r  <= mk_a_r;
    end
  end

  // Squares of the differences and marker times coordinate.
  logic [2*C-1:0]  sx_c_r [CORNERS];
  logic [2*C-1:0]  sy_c_r [CORNERS];
  logic [NC*PW-1:0] prod_c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CORNERS; k++) begin
        sx_c_r[k] <= dx_b_r[k] * dx_b_r[k];
        sy_c_r[k] <= dy_b_r[k] * dy_b_r[k];
      end
      for (int j = 0; j < NC; j++) prod_c_r[j*PW +: PW] <= PW'(mk_b_r) * PW'(crd_b_r[j]);
    end
  end

  // Squared side lengths.
  logic [2*W-1:0]   ss_d_r [CORNERS];
  logic [NC*PW-1:0] prod_d_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CORNERS; k++) ss_d_r[k] <= (2*W)'(sx_c_r[k]) + (2*W)'(sy_c_r[k]);
      prod_d_r <= prod_c_r;
    end
  end

  // Side lengths; products ride alongside.
  logic [W-1:0]     root [CORNERS];
  logic [NC*PW-1:0] prod_dl_r [W];
  for (genvar k = 0; k < CORNERS; k++) begin : g_root
    qpmm_sqrt #(.W(W)) u_sqrt (
      .clk  (clk),
      .en   (adv),
      .op   (ss_d_r[k]),
      .root (root[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_dl_r[0] <= prod_d_r;
      for (int i = 1; i < W; i++) prod_dl_r[i] <= prod_dl_r[i-1];
    end
  end

  // Mean side and the degenerate case.
  logic [W+1:0]     side_sum;
  logic [W-1:0]     mean_e_r;
  logic             deg_e_r;
  logic [NC*PW-1:0] prod_e_r;
  assign side_sum = (W+2)'(root[0]) + (W+2)'(root[1]) + (W+2)'(root[2]) + (W+2)'(root[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_e_r <= side_sum[W+1:2];
      deg_e_r  <= (side_sum[W+1:2] == '0);
      prod_e_r <= prod_dl_r[W-1];
    end
  end

  // Eight quotient pipelines; mean and flag follow them.
  logic [C-1:0] q     [NC];
  logic [NC-1:0] qsat;
  logic [W-1:0] mean_dl_r [C+1];
  logic         deg_dl_r  [C+1];
  for (genvar j = 0; j < NC; j++) begin : g_div
    qpmm_div #(.C(C)) u_div (
      .clk  (clk),
      .en   (adv),
      .num  ({prod_e_r[j*PW +: PW], {FRAC_BITS{1'b0}}}),
      .mean (mean_e_r),
      .q    (q[j]),
      .sat  (qsat[j])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_dl_r[0] <= mean_e_r;
      deg_dl_r[0]  <= deg_e_r;
      for (int i = 1; i <= C; i++) begin
        mean_dl_r[i] <= mean_dl_r[i-1];
        deg_dl_r[i]  <= deg_dl_r[i-1];
      end
    end
  end

  // Output register: clip, flag and pack.
  logic [OUT_W-1:0] data_nxt;
  logic             deg_w;
  assign deg_w = deg_dl_r[C];
  always_comb begin
    data_nxt = '0;
    for (int j = 0; j < NC; j++) begin
      data_nxt[j*C +: C] = deg_w ? '0 : (qsat[j] ? '1 : q[j]);
    end
    data_nxt[NC*C +: W] = deg_w ? '0 : mean_dl_r[C];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata         <= data_nxt;
      out_tuser[TU_SAT] <= !deg_w && (|qsat);
      out_tuser[TU_DEG] <= deg_w;
    end
  end

endmodule
`default_nettype wire

/* sv/qpmm_checker.sv */
`default_nettype none
module qpmm_checker #(
  parameter int COORD_BITS = qpmm_pkg::COORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [((8*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic [((9*COORD_BITS+8)/8)*8-1:0] out_tdata,
  input wire logic [qpmm_pkg::TU_W-1:0] out_tuser,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic cfg_psel,
  input wire logic cfg_penable,
  input wire logic cfg_pwrite,
  input wire logic [qpmm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [qpmm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input wire logic [qpmm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input wire logic cfg_pready
);
  import qpmm_pkg::*;

  localparam int C = COORD_BITS;

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A degenerate quad gives all zeros and no clip flag.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_DEG] |-> out_tdata == '0 && !out_tuser[TU_SAT])
    else $error("degenerate result not cleared");

  // A non-degenerate quad reports a nonzero mean side.
  a_mean_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[TU_DEG] |-> out_tdata[8*C +: C+1] != '0)
    else $error("zero mean side without degenerate flag");

  // A written marker size reads back on the next cycle.
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
    cfg_paddr[CFG_ADDR_W-1] == REG_MARKER
    |=> cfg_prdata[MARKER_W-1:0] == $past(cfg_pwdata[MARKER_W-1:0]))
    else $error("marker size read-back mismatch");

endmodule

bind quad_pixel_to_mm_scaler_unit qpmm_checker #(.COORD_BITS(COORD_BITS)) u_qpmm_checker (.*);
`default_nettype wire

/* verif/quad_pixel_to_mm_scaler_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module quad_pixel_to_mm_scaler_unit_tb;
  import qpmm_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int IN_W     = ((8*CB+7)/8)*8;
  localparam int OUT_W    = ((9*CB+8)/8)*8;
  localparam int LATENCY  = 2*CB+8;
  localparam int WDOG_MAX = 4000;

  typedef struct packed {
    logic [OUT_W-1:0] d;
    logic [TU_W-1:0]  u;
  } scaled_quad_t;

  typedef struct {
    logic [MARKER_W-1:0] marker;
    logic [IN_W-1:0]     quad;
    bit                  typed;
    scaled_quad_t        res;
  } quad_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [TU_W-1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  scaled_quad_t pending_mm[$];
  logic [MARKER_W-1:0] cur_marker = MARKER_RESET;
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  quad_pixel_to_mm_scaler_unit u_dut (.*);

  // Exact floor square root, two bits per step.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2*i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Mean closed-loop side and the corners scaled by marker size over it.
  function automatic scaled_quad_t scale_quad(logic [IN_W-1:0] q);
    logic [63:0] cx[CORNERS];
    logic [63:0] cy[CORNERS];
    logic [63:0] sum;
    logic [63:0] mean;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] num;
    logic [63:0] quo;
    int n;
    scaled_quad_t r;
    sum = 0;
    r = '0;
    for (int k = 0; k < CORNERS; k++) begin
      cx[k] = q[2*k*CB +: CB];
      cy[k] = q[(2*k+1)*CB +: CB];
    end
    for (int k = 0; k < CORNERS; k++) begin
      n = (k + 1) % CORNERS;
      dx = cx[k] >= cx[n] ? cx[k] - cx[n] : cx[n] - cx[k];
      dy = cy[k] >= cy[n] ? cy[k] - cy[n] : cy[n] - cy[k];
      sum += floor_root(dx*dx + dy*dy);
    end
    mean = sum >> 2;
    if (mean == 0) begin
      r.u[TU_DEG] = 1'b1;
      return r;
    end
    for (int k = 0; k < 2*CORNERS; k++) begin
      num = 64'(cur_marker) * ((k & 1) ? cy[k>>1] : cx[k>>1]) * (64'd1 << FRAC_BITS);
      quo = (2*num + mean) / (2*mean);
      if (quo > {CB{1'b1}}) begin
        quo = {CB{1'b1}};
        r.u[TU_SAT] = 1'b1;
      end
      r.d[k*CB +: CB] = quo[CB-1:0];
    end
    r.d[8*CB +: CB+1] = mean[CB:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result side: random stalls, and each transfer checked against the oldest expectation.
  always @(posedge clk) begin
    scaled_quad_t want;
    out_tready <= calm || ($urandom_range(99) >= 8);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mm.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], 0);
      end else begin
        want = pending_mm.pop_front();
        for (int k = 0; k < 2*CORNERS; k++) begin
          if (out_tdata[k*CB +: CB] !== want.d[k*CB +: CB])
            report_mismatch($sformatf("mm%0d_%s", k/2, (k & 1) ? "y" : "x"),
                            out_tdata[k*CB +: CB], want.d[k*CB +: CB]);
        end
        if (out_tdata[8*CB +: CB+1] !== want.d[8*CB +: CB+1])
          report_mismatch("mean_side_px", out_tdata[8*CB +: CB+1], want.d[8*CB +: CB+1]);
        if (out_tuser[TU_SAT] !== want.u[TU_SAT])
          report_mismatch("saturated", out_tuser[TU_SAT], want.u[TU_SAT]);
        if (out_tuser[TU_DEG] !== want.u[TU_DEG])
          report_mismatch("degenerate", out_tuser[TU_DEG], want.u[TU_DEG]);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait for every expected result, then let the pipeline drain.
  task automatic drain_quads();
    in_tvalid <= 1'b0;
    while (pending_mm.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_marker(logic [CFG_DATA_W-1:0] value);
    drain_quads();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_ADDR_W'(REG_MARKER) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_marker = value[MARKER_W-1:0];
  endtask

  // One quad transfer, sometimes preceded by a random idle gap on the input; the expectation
  // is queued on acceptance.
  task automatic send_quad(logic [IN_W-1:0] q, bit typed, scaled_quad_t res);
    if (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= q;
    do @(posedge clk); while (!in_tready);
    pending_mm.push_back(typed ? res : scale_quad(q));
  endtask

  function automatic logic [IN_W-1:0] pack_quad(int x0, int y0, int x1, int y1,
                                                 int x2, int y2, int x3, int y3);
    return IN_W'({y3[CB-1:0], x3[CB-1:0], y2[CB-1:0], x2[CB-1:0],
                  y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]});
  endfunction

  // Mostly near-square quads with random placement, size and jitter; some noise and some degenerate ones.
  function automatic logic [IN_W-1:0] random_quad();
    int x0, y0, s, j;
    logic [IN_W-1:0] q;
    case ($urandom_range(9)) inside
      [0:1]: begin
        for (int k = 0; k < IN_W/32; k++) q[k*32 +: 32] = $urandom;
        return q;
      end
      2: begin
        x0 = $urandom_range(65535);
        y0 = $urandom_range(65535);
        return pack_quad(x0, y0, x0 + $urandom_range(1), y0, x0, y0 + $urandom_range(1),
                         x0, y0);
      end
      default: begin
        s = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 2000);
        x0 = $urandom_range(65535 - (s < 65535 ? s : 0));
        y0 = $urandom_range(65535 - (s < 65535 ? s : 0));
        j = $urandom_range(1, 64);
        return pack_quad(x0 + $urandom_range(j), y0 + $urandom_range(j),
                         x0 + s - $urandom_range(j), y0 + $urandom_range(j),
                         x0 + s - $urandom_range(j), y0 + s - $urandom_range(j),
                         x0 + $urandom_range(j), y0 + s - $urandom_range(j));
      end
    endcase
  endfunction

  quad_row_t rows[$];
  localparam scaled_quad_t DEGENERATE = '{d: '0, u: 2'b10};

  initial begin
    logic [MARKER_W-1:0] phase_marker[4];
    scaled_quad_t none;
    none = '0;
    phase_marker = '{MARKER_RESET, 10'd1023, 10'd1, 10'd0};

    // Directed quads: degenerate shapes, extremes, saturation, and the marker extremes.
    rows = '{
      '{MARKER_RESET, '0, 1'b1, DEGENERATE},
      '{MARKER_RESET, '1, 1'b1, DEGENERATE},
      '{MARKER_RESET, pack_quad(0, 0, 1, 0, 1, 0, 1, 0), 1'b1, DEGENERATE},
      '{MARKER_RESET, pack_quad(100, 100, 101, 100, 101, 101, 100, 101), 1'b0, none},
      '{MARKER_RESET, pack_quad(0, 0, 16, 0, 16, 16, 0, 16), 1'b0, none},
      '{MARKER_RESET, pack_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535), 1'b0, none},
      '{MARKER_RESET, pack_quad(65519, 65519, 65535, 65519, 65535, 65535, 65519, 65535),
        1'b0, none},
      '{MARKER_RESET, pack_quad(0, 0, 65535, 65535, 0, 0, 65535, 65535), 1'b0, none},
      '{MARKER_RESET, {8{16'hAAAA}}, 1'b1, DEGENERATE},
      '{MARKER_RESET, {4{16'h5555, 16'hAAAA}}, 1'b0, none},
      '{MARKER_RESET, {4{16'hAAAA, 16'h5555}}, 1'b0, none},
      '{10'd1023, pack_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535), 1'b0, none},
      '{10'd1023, pack_quad(1000, 1000, 1160, 1000, 1160, 1160, 1000, 1160), 1'b0, none},
      '{10'd1, pack_quad(2, 3, 65535, 7, 65530, 65535, 9, 65520), 1'b0, none},
      '{10'd1, pack_quad(0, 0, 1, 0, 1, 1, 0, 1), 1'b0, none},
      '{10'd0, pack_quad(10, 20, 500, 20, 500, 510, 10, 510), 1'b0, none},
      '{10'd0, '0, 1'b1, DEGENERATE}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].marker != cur_marker) write_marker(rows[i].marker);
      send_quad(rows[i].quad, rows[i].typed, rows[i].res);
    end

    // Random phases through several marker sizes, one with a random size.
    for (int p = 0; p < 5; p++) begin
      write_marker(p == 4 ? {2'($urandom_range(3)), 20'h0, 10'($urandom_range(1, 1023))}
                          : CFG_DATA_W'(phase_marker[p]));
      for (int i = 0; i < 170; i++) begin
        calm = (p == 1 && i >= 40 && i < 120);
        if (p == 2 && i == 85) begin
          in_tvalid <= 1'b0;
          while (pending_mm.size() != 0) @(posedge clk);
        end
        send_quad(random_quad(), 1'b0, none);
      end
    end
    calm = 1'b0;

    drain_quads();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
sv/qpmm_pkg.sv
sv/qpmm_sqrt.sv
sv/qpmm_div.sv
sv/quad_pixel_to_mm_scaler_unit.sv
sv/qpmm_checker.sv
verif/quad_pixel_to_mm_scaler_unit_tb.sv
